@@ rtl/bbcm_pkg.sv @@
package bbcm_pkg;

   localparam int unsigned LIST_BITS = 2;
   localparam int unsigned REF_BITS = 8;
   localparam int unsigned STATUS_BITS = 3;
   localparam int unsigned KIND_BITS = 2;
   localparam int unsigned IDX_BITS = 6;
   localparam int unsigned COUNT_BITS = 7;

   typedef enum logic [LIST_BITS-1:0] {
      LIST_UNUSED = 2'd0,
      LIST_CLEAN  = 2'd1,
      LIST_DIRTY  = 2'd2,
      LIST_REF    = 2'd3
   } list_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_GET      = 2'd0,
      KIND_GET_READ = 2'd1,
      KIND_GET_NEW  = 2'd2,
      KIND_RELEASE  = 2'd3
   } kind_type;

   localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NO_SLOT  = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_REL_OK   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_ERROR    = 3'd4;

   typedef struct packed {
      logic load;
      logic search;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic is_release;
   } stat_type;

endpackage

@@ rtl/bbcm_ctrl.sv @@
module bbcm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  bbcm_pkg::stat_type  stat,
   output logic                busy,
   output bbcm_pkg::cmd_type   cmd
);
   import bbcm_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      busy_in = busy_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SEARCH;
               busy_in = 1'b1;
            end
         end
         S_SEARCH: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            state_in = S_IDLE;
            busy_in = 1'b0;
         end
         default: begin
            state_in = S_IDLE;
            busy_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign cmd.load = (state_ff == S_IDLE) && start;
   assign cmd.search = (state_ff == S_SEARCH) && !stat.is_release;
   assign cmd.commit = (state_ff == S_COMMIT);
endmodule

@@ rtl/bbcm_datapath.sv @@
module bbcm_datapath #(
   parameter int unsigned NUM_SLOTS = 64,
   parameter int unsigned KEY_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bbcm_pkg::cmd_type                cmd,
   output bbcm_pkg::stat_type               stat,
   input  logic [bbcm_pkg::KIND_BITS-1:0]   req_kind,
   input  logic [63:0]                      req_block_key,
   input  logic [bbcm_pkg::IDX_BITS-1:0]    req_slot_index,
   input  logic                             req_at_tail,
   input  logic                             req_mark_dirty,
   output logic                             rsp_valid,
   output logic [bbcm_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [bbcm_pkg::IDX_BITS-1:0]    rsp_slot_out,
   output logic [63:0]                      rsp_evicted_key,
   output logic                             rsp_writeback_needed,
   output logic                             rsp_read_needed,
   output logic                             rsp_zero_fill,
   output logic [bbcm_pkg::COUNT_BITS-1:0]  rsp_dirty_count
);
   import bbcm_pkg::*;

   localparam int unsigned SB = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int unsigned PB = $clog2(NUM_SLOTS + 1);
   localparam logic [SB-1:0] NEWEST = SB'(NUM_SLOTS - 1);
   localparam int unsigned PAD = 1 << SB;

   logic [KEY_BITS-1:0]  key_ff [NUM_SLOTS];
   list_type             list_ff [NUM_SLOTS];
   logic [REF_BITS-1:0]  rc_ff [NUM_SLOTS];
   logic                 dirty_ff [NUM_SLOTS];
   logic                 loaded_ff [NUM_SLOTS];
   logic [SB-1:0]        rec_ff [NUM_SLOTS];
   logic [PB-1:0]        pop_ff [4];

   logic [KIND_BITS-1:0] kind_ff;
   logic [KEY_BITS-1:0]  qkey_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic                 tail_ff, mdirty_ff;

   logic                 hit_ff, have_ff;
   logic [SB-1:0]        sel_ff;
   list_type             vlist_ff;

   logic                 hit_in, have_in;
   logic [SB-1:0]        hit_idx, best_idx;
   list_type             vlist;

   logic                 t_ok [2*PAD];
   logic [SB-1:0]        t_idx [2*PAD];
   logic [SB-1:0]        t_rec [2*PAD];

   always_comb begin
      hit_in = 1'b0;
      hit_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (list_ff[i] != LIST_UNUSED && key_ff[i] == qkey_ff) begin
            hit_in = 1'b1;
            hit_idx = SB'(i);
         end
      end
      if (pop_ff[LIST_UNUSED] != '0) vlist = LIST_UNUSED;
      else if (pop_ff[LIST_CLEAN] != '0) vlist = LIST_CLEAN;
      else vlist = LIST_DIRTY;
      for (int n = 0; n < 2 * PAD; n++) begin
         t_ok[n] = 1'b0;
         t_idx[n] = '0;
         t_rec[n] = '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         t_ok[PAD + i] = (list_ff[i] == vlist) && (rc_ff[i] == '0);
         t_idx[PAD + i] = SB'(i);
         t_rec[PAD + i] = rec_ff[i];
      end
      for (int n = PAD - 1; n >= 1; n--) begin
         if (t_ok[2*n] && (!t_ok[2*n+1] || t_rec[2*n] < t_rec[2*n+1])) begin
            t_ok[n] = t_ok[2*n];
            t_idx[n] = t_idx[2*n];
            t_rec[n] = t_rec[2*n];
         end else begin
            t_ok[n] = t_ok[2*n+1];
            t_idx[n] = t_idx[2*n+1];
            t_rec[n] = t_rec[2*n+1];
         end
      end
      have_in = t_ok[1];
      best_idx = t_idx[1];
   end

   assign stat.is_release = (kind_ff == KIND_RELEASE);

   function automatic logic req_dirty_eff(input logic a, input logic b);
      return a | b;
   endfunction

   logic             rel_ok;
   logic [SB-1:0]    s;
   logic             granted;
   list_type         cur_list, dest;
   logic [SB-1:0]    r;
   logic             move, to_old;
   logic [REF_BITS-1:0] rc_eff;
   logic             ld_eff, dirty_eff;
   logic [PB-1:0]    pop_in [4];

   always_comb begin
      rel_ok = (kind_ff == KIND_RELEASE) && (32'(idx_ff) < NUM_SLOTS);
      s = (kind_ff == KIND_RELEASE) ? SB'(idx_ff) : sel_ff;
      granted = (kind_ff != KIND_RELEASE) && (hit_ff || have_ff);
      cur_list = list_ff[s];
      dest = LIST_REF;
      move = 1'b0;
      if (rel_ok) begin
         move = 1'b1;
         dest = (req_dirty_eff(mdirty_ff, dirty_ff[s])) ? LIST_DIRTY : LIST_CLEAN;
      end else if (granted && !hit_ff) begin
         move = 1'b1;
      end
      to_old = rel_ok && tail_ff;
      r = rec_ff[s];
      for (int j = 0; j < 4; j++) pop_in[j] = pop_ff[j];
      if (move) begin
         pop_in[cur_list] = pop_in[cur_list] - PB'(1);
         pop_in[dest] = pop_in[dest] + PB'(1);
      end
      rc_eff = (granted && !hit_ff) ? '0 : rc_ff[s];
      ld_eff = (granted && !hit_ff) ? 1'b0 : loaded_ff[s];
      dirty_eff = (granted && !hit_ff) ? 1'b0 : dirty_ff[s];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         qkey_ff <= req_block_key[KEY_BITS-1:0];
         idx_ff <= req_slot_index;
         tail_ff <= req_at_tail;
         mdirty_ff <= req_mark_dirty;
      end
      if (cmd.search) begin
         hit_ff <= hit_in;
         have_ff <= have_in;
         sel_ff <= hit_in ? hit_idx : best_idx;
         vlist_ff <= vlist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            key_ff[i] <= '0;
            list_ff[i] <= LIST_UNUSED;
            rc_ff[i] <= '0;
            dirty_ff[i] <= 1'b0;
            loaded_ff[i] <= 1'b0;
            rec_ff[i] <= SB'(i);
         end
         pop_ff[LIST_UNUSED] <= PB'(NUM_SLOTS);
         pop_ff[LIST_CLEAN] <= '0;
         pop_ff[LIST_DIRTY] <= '0;
         pop_ff[LIST_REF] <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.commit;
         if (cmd.commit) begin
            rsp_status <= ST_NO_SLOT;
            rsp_slot_out <= '0;
            rsp_evicted_key <= '0;
            rsp_writeback_needed <= 1'b0;
            rsp_read_needed <= 1'b0;
            rsp_zero_fill <= 1'b0;
            rsp_dirty_count <= COUNT_BITS'(pop_in[LIST_DIRTY]);
            if (kind_ff == KIND_RELEASE) begin
               rsp_slot_out <= idx_ff;
               rsp_status <= ST_ERROR;
               if (rel_ok) begin
                  if (rc_ff[s] != '0) begin
                     rsp_status <= ST_REL_OK;
                     rc_ff[s] <= rc_ff[s] - REF_BITS'(1);
                  end
                  if (mdirty_ff) dirty_ff[s] <= 1'b1;
               end
            end else if (granted) begin
               rsp_slot_out <= IDX_BITS'(s);
               rsp_status <= hit_ff ? ST_HIT : ST_MISS;
               if (!hit_ff) begin
                  rsp_evicted_key <= 64'(key_ff[s]);
                  rsp_writeback_needed <= (vlist_ff == LIST_DIRTY);
                  key_ff[s] <= qkey_ff;
               end
               rsp_read_needed <= (kind_ff == KIND_GET_READ) && !ld_eff;
               rsp_zero_fill <= (kind_ff == KIND_GET_NEW);
               dirty_ff[s] <= (kind_ff == KIND_GET_NEW) ? 1'b1 : dirty_eff;
               loaded_ff[s] <= 1'b1;
               if (rc_eff == '1) begin
                  rsp_status <= ST_ERROR;
                  rc_ff[s] <= rc_eff;
               end else begin
                  rc_ff[s] <= rc_eff + REF_BITS'(1);
               end
            end
            if (move) list_ff[s] <= dest;
            if (rel_ok || granted) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (to_old) begin
                     if (rec_ff[i] < r) rec_ff[i] <= rec_ff[i] + SB'(1);
                  end else begin
                     if (rec_ff[i] > r) rec_ff[i] <= rec_ff[i] - SB'(1);
                  end
               end
               rec_ff[s] <= to_old ? '0 : NEWEST;
            end
            for (int j = 0; j < 4; j++) pop_ff[j] <= pop_in[j];
         end
      end
   end
endmodule

@@ rtl/block_buffer_cache_manager.sv @@
// A request taken while idle passes the search and commit states before its word shows on rsp_.
// Busy stays high from acceptance until the word shows. In parallel, search matches used slot
// keys and picks the oldest unreferenced victim: unused, else clean, else dirty slot.
// Reset is synchronous and active high; every slot becomes unused and ranks follow slot order.
// The receiver cannot stall: each word is shown for exactly one cycle under rsp_valid.
module block_buffer_cache_manager #(
   parameter int unsigned NUM_SLOTS = 64,
   parameter int unsigned KEY_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [bbcm_pkg::KIND_BITS-1:0]   req_kind,
   input  logic [63:0]                      req_block_key,
   input  logic [bbcm_pkg::IDX_BITS-1:0]    req_slot_index,
   input  logic                             req_at_tail,
   input  logic                             req_mark_dirty,
   output logic                             rsp_valid,
   output logic [bbcm_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [bbcm_pkg::IDX_BITS-1:0]    rsp_slot_out,
   output logic [63:0]                      rsp_evicted_key,
   output logic                             rsp_writeback_needed,
   output logic                             rsp_read_needed,
   output logic                             rsp_zero_fill,
   output logic [bbcm_pkg::COUNT_BITS-1:0]  rsp_dirty_count
);
   import bbcm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bbcm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat), .busy(busy), .cmd(cmd)
   );

   bbcm_datapath #(.NUM_SLOTS(NUM_SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_kind(req_kind), .req_block_key(req_block_key),
      .req_slot_index(req_slot_index), .req_at_tail(req_at_tail),
      .req_mark_dirty(req_mark_dirty), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_slot_out(rsp_slot_out),
      .rsp_evicted_key(rsp_evicted_key),
      .rsp_writeback_needed(rsp_writeback_needed),
      .rsp_read_needed(rsp_read_needed), .rsp_zero_fill(rsp_zero_fill),
      .rsp_dirty_count(rsp_dirty_count)
   );
endmodule

@@ rtl/bbcm_checker.sv @@
module bbcm_port_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [bbcm_pkg::STATUS_BITS-1:0] rsp_status,
   input logic                             rsp_writeback_needed
);
   import bbcm_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted request did not raise busy");

   a_word_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_valid) else $error("word missing three cycles after request");

   a_word_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("word shown for more than one cycle");

   a_wb_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_writeback_needed |-> rsp_status == ST_MISS || rsp_status == ST_ERROR)
      else $error("writeback without a miss");

   a_valid_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("word shown while still busy");
endmodule

bind block_buffer_cache_manager bbcm_port_checker u_bbcm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_writeback_needed(rsp_writeback_needed)
);
